// ----- rtl/mst_sched_pkg.sv -----
// ----------------------------------------------------------------------------
// Timer scheduler package
// Shared constants, command and status codes, and the slot entry type.
// ----------------------------------------------------------------------------
package mst_sched_pkg;

   localparam int NUM_TIMERS_DEF = 16;
   localparam int MAX_RESULTS    = 16;
   localparam int FIRE_CNT_W     = $clog2(MAX_RESULTS + 1);

   localparam logic [2:0] CMD_ADD        = 3'd0;
   localparam logic [2:0] CMD_CANCEL     = 3'd1;
   localparam logic [2:0] CMD_CANCEL_TAG = 3'd2;
   localparam logic [2:0] CMD_CANCEL_ALL = 3'd3;
   localparam logic [2:0] CMD_UPDATE     = 3'd4;
   localparam logic [2:0] CMD_TICK       = 3'd5;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_FULL       = 2'd1;
   localparam logic [1:0] ST_BAD_PERIOD = 2'd2;
   localparam logic [1:0] ST_BAD_SLOT   = 2'd3;

   localparam logic KIND_REPLY  = 1'b0;
   localparam logic KIND_EXPIRY = 1'b1;

   typedef struct packed {
      logic [63:0] tag;
      logic [31:0] period;
      logic [63:0] deadline;
   } slot_entry_type;

endpackage

// ----- rtl/multi_slot_timer_scheduler.sv -----
// ----------------------------------------------------------------------------
// Multi-slot timer scheduler
// A table of timer slots held in one synchronous memory, with valid bits in
// flip-flops. Every command is one scan over the table followed by delivery.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Beat
//  req_      in         req_valid/req_stall   one command
//  rsp_      out        rsp_valid/rsp_stall   one reply or expiry
//  csr_      in         csr_wr_en             min_period write
//
// Each command is a scan over every slot followed by a decision. A tick that
// fires then walks the fired slots, reading each back through the single read
// port of the slot memory for its expiry beat and passing over the rest. Reset
// is synchronous and clears the valid bits, the control state and the output
// valid, and sets min_period to 1; the slot memory is not cleared. A stalled
// result holds in the output register; the next command is taken while it waits.
module multi_slot_timer_scheduler #(
   parameter int NUM_TIMERS = mst_sched_pkg::NUM_TIMERS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [63:0] req_now,
   input  logic [31:0] req_start_delay,
   input  logic [31:0] req_period,
   input  logic [63:0] req_tag,
   input  logic [3:0]  req_timer_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_slot_index,
   output logic [63:0] rsp_owner_tag,
   output logic [63:0] rsp_fire_time,
   output logic [4:0]  rsp_active_count,
   output logic [63:0] rsp_next_due,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);
   localparam int FC_W  = mst_sched_pkg::FIRE_CNT_W;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_FIND  = 2'd2;
   localparam logic [1:0] S_LOAD  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [31:0] min_period_ff;

   logic [2:0]  cmd_ff;
   logic [63:0] now_ff, tag_ff;
   logic [31:0] delay_ff, period_ff;
   logic [3:0]  id_ff;
   logic        period_ok_ff;

   logic [NUM_TIMERS-1:0] valid_ff, valid_in;
   logic [NUM_TIMERS-1:0] fired_ff, fired_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [63:0]           min_ff, min_in;
   logic [FC_W-1:0]       fire_cnt_ff, fire_cnt_in;
   logic [FC_W-1:0]       emitted_ff, emitted_in;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      slot_ff, slot_in;
   logic [1:0]            status_ff, status_in;
   logic [IDX_W-1:0]      ptr_ff, ptr_in;

   mst_sched_pkg::slot_entry_type mem [NUM_TIMERS];
   mst_sched_pkg::slot_entry_type rd_ff, wr_data;
   logic             rd_en, wr_en;
   logic [IDX_W-1:0] rd_addr, wr_addr;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        kind_ff, kind_in, last_ff, last_in;
   logic [1:0]  rstat_ff, rstat_in;
   logic [3:0]  rslot_ff, rslot_in;
   logic [63:0] rtag_ff, rtag_in, rtime_ff, rtime_in, rdue_ff, rdue_in;
   logic [4:0]  ract_ff, ract_in;

   logic             accept, out_free, load;
   logic             proc;
   logic [IDX_W-1:0] pidx;
   logic             pv, nv, match_id, tag_eq, expired;
   logic [63:0]      nd;
   logic             req_period_ok;

   assign accept        = req_valid && (state_ff == S_IDLE);
   assign req_stall     = (state_ff != S_IDLE);
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign req_period_ok = (req_period == 32'd0) || (req_period >= min_period_ff);

   assign proc     = (state_ff == S_SCAN) && (cnt_ff != '0);
   assign pidx     = IDX_W'(cnt_ff - CNT_W'(1));
   assign pv       = valid_ff[pidx];
   assign tag_eq   = (rd_ff.tag == tag_ff);
   assign match_id = ((IDX_W + 4)'(pidx) == (IDX_W + 4)'(id_ff));
   assign expired  = (now_ff >= rd_ff.deadline);

   always_comb begin
      state_in    = state_ff;
      valid_in    = valid_ff;
      fired_in    = fired_ff;
      cnt_in      = cnt_ff;
      count_in    = count_ff;
      min_in      = min_ff;
      fire_cnt_in = fire_cnt_ff;
      emitted_in  = emitted_ff;
      found_in    = found_ff;
      slot_in     = slot_ff;
      status_in   = status_ff;
      ptr_in      = ptr_ff;
      rd_en       = 1'b0;
      rd_addr     = '0;
      wr_en       = 1'b0;
      wr_addr     = pidx;
      wr_data     = rd_ff;
      nv          = pv;
      nd          = rd_ff.deadline;
      load        = 1'b0;
      kind_in     = mst_sched_pkg::KIND_REPLY;
      rstat_in    = mst_sched_pkg::ST_OK;
      rslot_in    = 4'd0;
      rtag_in     = 64'd0;
      rtime_in    = 64'd0;
      last_in     = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in    = S_SCAN;
               fired_in    = '0;
               cnt_in      = '0;
               count_in    = '0;
               min_in      = '1;
               fire_cnt_in = '0;
               emitted_in  = '0;
               found_in    = 1'b0;
               slot_in     = '0;
               ptr_in      = '0;
               status_in   = mst_sched_pkg::ST_OK;
               if (req_cmd == mst_sched_pkg::CMD_ADD && !req_period_ok) begin
                  status_in = mst_sched_pkg::ST_BAD_PERIOD;
               end else if ((req_cmd == mst_sched_pkg::CMD_CANCEL ||
                             req_cmd == mst_sched_pkg::CMD_UPDATE) &&
                            (32'(req_timer_id) >= 32'(NUM_TIMERS))) begin
                  status_in = mst_sched_pkg::ST_BAD_SLOT;
               end
            end
         end
         S_SCAN: begin
            if (cnt_ff < CNT_W'(NUM_TIMERS)) begin
               rd_en   = 1'b1;
               rd_addr = IDX_W'(cnt_ff);
               cnt_in  = cnt_ff + CNT_W'(1);
            end else begin
               state_in = S_FIND;
            end
            if (proc) begin
               unique case (cmd_ff)
                  mst_sched_pkg::CMD_ADD: begin
                     if (period_ok_ff && !found_ff && !pv) begin
                        nv       = 1'b1;
                        nd       = now_ff + 64'(delay_ff);
                        wr_en    = 1'b1;
                        wr_data  = '{tag: tag_ff, period: period_ff, deadline: nd};
                        found_in = 1'b1;
                        slot_in  = pidx;
                     end
                  end
                  mst_sched_pkg::CMD_CANCEL: begin
                     if (match_id && pv && tag_eq) nv = 1'b0;
                  end
                  mst_sched_pkg::CMD_UPDATE: begin
                     if (match_id && pv && tag_eq) begin
                        if (period_ok_ff) begin
                           nd      = now_ff + 64'(period_ff);
                           wr_en   = 1'b1;
                           wr_data = '{tag: tag_ff, period: period_ff, deadline: nd};
                        end else begin
                           status_in = mst_sched_pkg::ST_BAD_PERIOD;
                        end
                     end
                  end
                  mst_sched_pkg::CMD_CANCEL_TAG: begin
                     if (tag_eq) nv = 1'b0;
                  end
                  mst_sched_pkg::CMD_CANCEL_ALL: begin
                     nv = 1'b0;
                  end
                  mst_sched_pkg::CMD_TICK: begin
                     if (pv && expired &&
                         (fire_cnt_ff < FC_W'(mst_sched_pkg::MAX_RESULTS))) begin
                        fired_in[pidx] = 1'b1;
                        fire_cnt_in    = fire_cnt_ff + FC_W'(1);
                        nd             = now_ff + 64'(rd_ff.period);
                        nv             = (rd_ff.period != 32'd0);
                        wr_en          = 1'b1;
                        wr_data.deadline = nd;
                     end
                  end
                  default: begin
                  end
               endcase
               valid_in[pidx] = nv;
               if (nv) begin
                  count_in = count_ff + CNT_W'(1);
                  if (nd < min_ff) min_in = nd;
               end
            end
         end
         S_FIND: begin
            if (fire_cnt_ff == '0) begin
               rstat_in = status_ff;
               if (cmd_ff == mst_sched_pkg::CMD_ADD && status_ff == mst_sched_pkg::ST_OK)
               begin
                  if (found_ff) rslot_in = 4'(slot_ff);
                  else          rstat_in = mst_sched_pkg::ST_FULL;
               end
               if (out_free) begin
                  load     = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (fired_ff[ptr_ff]) begin
               rd_en    = 1'b1;
               rd_addr  = ptr_ff;
               state_in = S_LOAD;
            end else begin
               ptr_in = ptr_ff + IDX_W'(1);
            end
         end
         S_LOAD: begin
            kind_in  = mst_sched_pkg::KIND_EXPIRY;
            rslot_in = 4'(ptr_ff);
            rtag_in  = rd_ff.tag;
            rtime_in = now_ff;
            last_in  = (emitted_ff + FC_W'(1) == fire_cnt_ff);
            if (out_free) begin
               load       = 1'b1;
               emitted_in = emitted_ff + FC_W'(1);
               ptr_in     = ptr_ff + IDX_W'(1);
               state_in   = last_in ? S_IDLE : S_FIND;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && rsp_stall);
      ract_in      = 5'(count_ff);
      rdue_in      = min_ff;
   end

   // Scan writes go to the entry read in the previous cycle, never the one being read.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         min_period_ff <= 32'd1;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) min_period_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      fired_ff    <= fired_in;
      cnt_ff      <= cnt_in;
      count_ff    <= count_in;
      min_ff      <= min_in;
      fire_cnt_ff <= fire_cnt_in;
      emitted_ff  <= emitted_in;
      found_ff    <= found_in;
      slot_ff     <= slot_in;
      status_ff   <= status_in;
      ptr_ff      <= ptr_in;
      if (accept) begin
         cmd_ff       <= req_cmd;
         now_ff       <= req_now;
         tag_ff       <= req_tag;
         delay_ff     <= req_start_delay;
         period_ff    <= req_period;
         id_ff        <= req_timer_id;
         period_ok_ff <= req_period_ok;
      end
      if (load) begin
         kind_ff  <= kind_in;
         rstat_ff <= rstat_in;
         rslot_ff <= rslot_in;
         rtag_ff  <= rtag_in;
         rtime_ff <= rtime_in;
         ract_ff  <= ract_in;
         rdue_ff  <= rdue_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_status       = rstat_ff;
   assign rsp_slot_index   = rslot_ff;
   assign rsp_owner_tag    = rtag_ff;
   assign rsp_fire_time    = rtime_ff;
   assign rsp_active_count = ract_ff;
   assign rsp_next_due     = rdue_ff;
   assign rsp_last         = last_ff;

endmodule

// ----- rtl/mst_sched_checker.sv -----
// ----------------------------------------------------------------------------
// Timer scheduler port checker
// Watches the top level's ports and flags behaviour the block must never show.
// ----------------------------------------------------------------------------
module mst_sched_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_kind,
   input logic [1:0]  rsp_status,
   input logic [63:0] rsp_owner_tag,
   input logic [63:0] rsp_fire_time,
   input logic [63:0] rsp_next_due,
   input logic        rsp_last
);

   // An accepted command sets req_stall once it has been taken.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("command accepted while the previous one was not finished");

   // Expiry beats always report success.
   a_expiry_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == mst_sched_pkg::KIND_EXPIRY) |->
      rsp_status == mst_sched_pkg::ST_OK)
      else $error("expiry beat with a failure status");

   // Command replies carry no tag and no fire time and are always the last beat.
   a_reply_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == mst_sched_pkg::KIND_REPLY) |->
      (rsp_owner_tag == 64'd0 && rsp_fire_time == 64'd0 && rsp_last))
      else $error("reply beat with expiry fields set or not final");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_next_due)))
      else $error("stalled result beat changed");

endmodule

bind multi_slot_timer_scheduler mst_sched_checker u_mst_sched_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_kind      (rsp_kind),
   .rsp_status    (rsp_status),
   .rsp_owner_tag (rsp_owner_tag),
   .rsp_fire_time (rsp_fire_time),
   .rsp_next_due  (rsp_next_due),
   .rsp_last      (rsp_last)
);
